### rtl/nwalk_pkg.sv
// Shared types and register codes of the NCHW to NC1HWC0 address walker.
`default_nettype none
package nwalk_pkg;

    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_BATCH_COUNT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_CHANNELS = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEM_BYTES     = 3'd5;

    // Saturation limits of the spatial, block and element-size registers
    localparam logic [12:0] MAX_HW = 13'd4096;
    localparam logic [5:0]  MAX_C0 = 6'd32;
    localparam logic [3:0]  MAX_EB = 4'd8;

    // Cycles from a register write until the derived strides are settled
    localparam int GEOM_LATENCY = 4;

    typedef struct packed {
        logic [15:0] n;          // batch count, clamped
        logic [15:0] c;          // channel count, clamped
        logic [12:0] h;          // height, clamped
        logic [12:0] w;          // width, clamped
        logic [5:0]  c0;         // block channels, clamped
        logic [3:0]  eb;         // element bytes, clamped
        logic [29:0] hweb;       // H*W*eb: one channel plane in bytes
        logic [35:0] blk_step;   // C0*H*W*eb: one channel block in bytes
        logic [45:0] chw;        // C*H*W*eb: one batch item in bytes
        logic        busy;       // strides still settling
        logic        restart;    // register written: walk starts again
    } t_geom;

endpackage
`default_nettype wire

### rtl/nwalk_cfg.sv
// Configuration registers, clamping and derived stride products.
`default_nettype none
module nwalk_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [nwalk_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [nwalk_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output nwalk_pkg::t_geom                         o_geom
);
    import nwalk_pkg::*;

    localparam int CNT_BITS = $clog2(GEOM_LATENCY + 1);

    logic [15:0] r_batch_count, r_channel_count;
    logic [12:0] r_height, r_width;
    logic [5:0]  r_block_channels;
    logic [3:0]  r_elem_bytes;

    logic [15:0] r_n, r_c;
    logic [12:0] r_h, r_w;
    logic [5:0]  r_c0;
    logic [3:0]  r_eb;
    logic [25:0] r_hw;
    logic [29:0] r_hweb;
    logic [35:0] r_blk_step;
    logic [45:0] r_chw;

    logic [CNT_BITS-1:0] r_busy_cnt, n_busy_cnt;
    logic                r_restart;
    logic                write_hit;

    always_comb begin
        write_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BATCH_COUNT, REG_CHANNEL_COUNT, REG_HEIGHT,
                REG_WIDTH, REG_BLOCK_CHANNELS, REG_ELEM_BYTES: write_hit = 1'b1;
                default: write_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_count    <= 16'd1;
            r_channel_count  <= 16'd16;
            r_height         <= 13'd1;
            r_width          <= 13'd1;
            r_block_channels <= 6'd16;
            r_elem_bytes     <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BATCH_COUNT:    r_batch_count    <= i_cfg_data;
                REG_CHANNEL_COUNT:  r_channel_count  <= i_cfg_data;
                REG_HEIGHT:         r_height         <= i_cfg_data[12:0];
                REG_WIDTH:          r_width          <= i_cfg_data[12:0];
                REG_BLOCK_CHANNELS: r_block_channels <= i_cfg_data[5:0];
                REG_ELEM_BYTES:     r_elem_bytes     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp: zero counts as one, large sizes saturate
    always_ff @(posedge i_clk) begin
        r_n  <= (r_batch_count == '0) ? 16'd1 : r_batch_count;
        r_c  <= (r_channel_count == '0) ? 16'd1 : r_channel_count;
        r_h  <= (r_height == '0) ? 13'd1 : ((r_height > MAX_HW) ? MAX_HW : r_height);
        r_w  <= (r_width == '0) ? 13'd1 : ((r_width > MAX_HW) ? MAX_HW : r_width);
        r_c0 <= (r_block_channels == '0) ? 6'd1 :
                ((r_block_channels > MAX_C0) ? MAX_C0 : r_block_channels);
        r_eb <= (r_elem_bytes == '0) ? 4'd1 :
                ((r_elem_bytes > MAX_EB) ? MAX_EB : r_elem_bytes);
    end

    // Stride products: H*W, then *eb, then *C0 and *C side by side
    always_ff @(posedge i_clk) begin
        r_hw       <= 26'(r_h) * 26'(r_w);
        r_hweb     <= 30'(r_hw) * 30'(r_eb);
        r_blk_step <= 36'(r_hweb) * 36'(r_c0);
        r_chw      <= 46'(r_hweb) * 46'(r_c);
    end

    always_comb begin
        n_busy_cnt = r_busy_cnt;
        if (write_hit) begin
            n_busy_cnt = CNT_BITS'(GEOM_LATENCY);
        end else if (r_busy_cnt != '0) begin
            n_busy_cnt = r_busy_cnt - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt <= CNT_BITS'(GEOM_LATENCY);
            r_restart  <= 1'b0;
        end else begin
            r_busy_cnt <= n_busy_cnt;
            r_restart  <= write_hit;
        end
    end

    always_comb begin
        o_geom.n        = r_n;
        o_geom.c        = r_c;
        o_geom.h        = r_h;
        o_geom.w        = r_w;
        o_geom.c0       = r_c0;
        o_geom.eb       = r_eb;
        o_geom.hweb     = r_hweb;
        o_geom.blk_step = r_blk_step;
        o_geom.chw      = r_chw;
        o_geom.busy     = (r_busy_cnt != '0) || r_restart;
        o_geom.restart  = r_restart;
    end

endmodule
`default_nettype wire

### rtl/nwalk_core.sv
// Walk counters, running byte offsets, input register and result register.
`default_nettype none
module nwalk_core #(
    parameter int ADDR_BITS = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nwalk_pkg::t_geom  i_geom,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_restart,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [39:0]            o_src_offset,
    output logic [39:0]            o_dst_offset,
    output logic                   o_pad,
    output logic                   o_last_element
);
    import nwalk_pkg::*;

    typedef logic [ADDR_BITS-1:0] t_addr;

    // Input register
    logic r_in_valid, r_in_restart;
    // Result register
    logic r_out_valid;
    t_addr r_out_src, r_out_dst;
    logic r_out_pad, r_out_last;

    // Walk position of the next element
    logic [4:0]  r_lane, n_lane;
    logic [11:0] r_col, n_col, r_row, n_row;
    logic [15:0] r_blk_ch, n_blk_ch;      // block index times C0
    logic [15:0] r_batch, n_batch;
    t_addr r_lane_off, n_lane_off;        // lane * H*W*eb
    t_addr r_pix_off, n_pix_off;          // (row*W + col) * eb
    t_addr r_blk_off, n_blk_off;          // batch and block part of the source
    t_addr r_batch_off, n_batch_off;      // batch * C*H*W*eb
    t_addr r_dst_off, n_dst_off;

    logic [4:0]  e_lane;
    logic [11:0] e_col, e_row;
    logic [15:0] e_blk_ch, e_batch;
    t_addr e_lane_off, e_pix_off, e_blk_off, e_batch_off, e_dst_off;

    logic        adv, fire;
    logic        lane_end, col_end, row_end, blk_end, batch_end, last_c, pad_c;
    logic [16:0] ch;
    t_addr       src_c, eb_a, hweb_a, blk_step_a, chw_a;

    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !i_geom.busy && (!r_in_valid || adv);

    assign eb_a       = t_addr'(i_geom.eb);
    assign hweb_a     = t_addr'(i_geom.hweb);
    assign blk_step_a = t_addr'(i_geom.blk_step);
    assign chw_a      = t_addr'(i_geom.chw);

    // Restart takes effect before the element is formed
    always_comb begin
        if (r_in_restart) begin
            e_lane = '0; e_col = '0; e_row = '0; e_blk_ch = '0; e_batch = '0;
            e_lane_off = '0; e_pix_off = '0; e_blk_off = '0;
            e_batch_off = '0; e_dst_off = '0;
        end else begin
            e_lane = r_lane; e_col = r_col; e_row = r_row;
            e_blk_ch = r_blk_ch; e_batch = r_batch;
            e_lane_off = r_lane_off; e_pix_off = r_pix_off; e_blk_off = r_blk_off;
            e_batch_off = r_batch_off; e_dst_off = r_dst_off;
        end
    end

    always_comb begin
        lane_end  = ({1'b0, e_lane} + 6'd1) >= i_geom.c0;
        col_end   = ({1'b0, e_col} + 13'd1) >= i_geom.w;
        row_end   = ({1'b0, e_row} + 13'd1) >= i_geom.h;
        blk_end   = ({1'b0, e_blk_ch} + 17'(i_geom.c0)) >= {1'b0, i_geom.c};
        batch_end = ({1'b0, e_batch} + 17'd1) >= {1'b0, i_geom.n};
        last_c    = lane_end && col_end && row_end && blk_end && batch_end;
        ch        = {1'b0, e_blk_ch} + 17'(e_lane);
        pad_c     = ch >= {1'b0, i_geom.c};
        src_c     = pad_c ? '0 : (e_blk_off + e_lane_off + e_pix_off);
    end

    // Next position: lane fastest, then column, row, block, batch
    always_comb begin
        n_lane = e_lane; n_col = e_col; n_row = e_row;
        n_blk_ch = e_blk_ch; n_batch = e_batch;
        n_lane_off = e_lane_off; n_pix_off = e_pix_off; n_blk_off = e_blk_off;
        n_batch_off = e_batch_off;
        n_dst_off = e_dst_off + eb_a;
        if (last_c) begin
            n_lane = '0; n_col = '0; n_row = '0; n_blk_ch = '0; n_batch = '0;
            n_lane_off = '0; n_pix_off = '0; n_blk_off = '0;
            n_batch_off = '0; n_dst_off = '0;
        end else if (!lane_end) begin
            n_lane     = e_lane + 5'd1;
            n_lane_off = e_lane_off + hweb_a;
        end else begin
            n_lane     = '0;
            n_lane_off = '0;
            n_pix_off  = e_pix_off + eb_a;
            if (!col_end) begin
                n_col = e_col + 12'd1;
            end else begin
                n_col = '0;
                if (!row_end) begin
                    n_row = e_row + 12'd1;
                end else begin
                    n_row     = '0;
                    n_pix_off = '0;
                    if (!blk_end) begin
                        n_blk_ch  = e_blk_ch + 16'(i_geom.c0);
                        n_blk_off = e_blk_off + blk_step_a;
                    end else begin
                        n_blk_ch    = '0;
                        n_batch     = e_batch + 16'd1;
                        n_batch_off = e_batch_off + chw_a;
                        n_blk_off   = e_batch_off + chw_a;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom.restart) begin
            r_lane <= '0; r_col <= '0; r_row <= '0; r_blk_ch <= '0; r_batch <= '0;
            r_lane_off <= '0; r_pix_off <= '0; r_blk_off <= '0;
            r_batch_off <= '0; r_dst_off <= '0;
        end else if (fire) begin
            r_lane <= n_lane; r_col <= n_col; r_row <= n_row;
            r_blk_ch <= n_blk_ch; r_batch <= n_batch;
            r_lane_off <= n_lane_off; r_pix_off <= n_pix_off; r_blk_off <= n_blk_off;
            r_batch_off <= n_batch_off; r_dst_off <= n_dst_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_restart <= i_restart;
        end
        if (fire) begin
            r_out_src  <= src_c;
            r_out_dst  <= e_dst_off;
            r_out_pad  <= pad_c;
            r_out_last <= last_c;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_src_offset   = 40'(r_out_src);
    assign o_dst_offset   = 40'(r_out_dst);
    assign o_pad          = r_out_pad;
    assign o_last_element = r_out_last;

    a_pad_zero_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pad |-> r_out_src == '0)
        else $error("padded element carries a source offset");

    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_restart |=> r_out_dst == '0)
        else $error("restart did not yield the first element");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last_c |=> r_lane == '0 && r_batch == '0 && r_dst_off == '0)
        else $error("walk did not wrap after the last element");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_geom.busy |-> !o_in_ready)
        else $error("transfer accepted while strides settle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("stalled item dropped from input register");

endmodule
`default_nettype wire

### rtl/nchw_to_nc1hwc0_address_walker_top.sv
// Top level of the NCHW to NC1HWC0 address walker.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_restart
//  out     | output    | o_out_valid / i_out_ready | o_src_offset, o_dst_offset,
//          |           |                           | o_pad, o_last_element
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One element per cycle while i_out_ready is high and strides are settled; an item
// passes the input register, then the result register around the walk counters.
// o_in_ready stays low after a write to one of the six registers, and after reset,
// while the stride multipliers (H*W, then *eb, then *C0 and *C side by side) settle.
// A stalled result holds the result register; the input register still takes one item.
`default_nettype none
module nchw_to_nc1hwc0_address_walker_top #(
    parameter int ADDR_BITS = 40
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_restart,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [39:0]                              o_src_offset,
    output logic [39:0]                              o_dst_offset,
    output logic                                     o_pad,
    output logic                                     o_last_element,
    input  wire logic                                i_cfg_we,
    input  wire logic [nwalk_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [nwalk_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import nwalk_pkg::*;

    t_geom geom;

    nwalk_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    nwalk_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_src_offset   (o_src_offset),
        .o_dst_offset   (o_dst_offset),
        .o_pad          (o_pad),
        .o_last_element (o_last_element)
    );

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the NCHW to NC1HWC0 address walker: predicts each element and checks it.

typedef struct packed {
    logic [39:0] src;
    logic [39:0] dst;
    logic        pad;
    logic        last;
} t_elem_addr;

class walk_scoreboard;
    localparam longint unsigned ADDR_MASK = 64'h0000_00FF_FFFF_FFFF;

    logic [15:0] n_reg;
    logic [15:0] c_reg;
    logic [12:0] h_reg;
    logic [12:0] w_reg;
    logic [5:0]  c0_reg;
    logic [3:0]  eb_reg;

    // Position of the next destination element
    longint unsigned bat, blk, row, col, lane, lin;

    t_elem_addr pending_elems[$];
    int         err_count;

    function new();
        n_reg     = 16'd1;
        c_reg     = 16'd16;
        h_reg     = 13'd1;
        w_reg     = 13'd1;
        c0_reg    = 6'd16;
        eb_reg    = 4'd2;
        err_count = 0;
        rewind();
    endfunction

    function void rewind();
        bat  = 0;
        blk  = 0;
        row  = 0;
        col  = 0;
        lane = 0;
        lin  = 0;
    endfunction

    function longint unsigned clampv(longint unsigned v, longint unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function int pending();
        return pending_elems.size();
    endfunction

    function void apply_write(logic [nwalk_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic [nwalk_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            nwalk_pkg::REG_BATCH_COUNT:    n_reg  = data[15:0];
            nwalk_pkg::REG_CHANNEL_COUNT:  c_reg  = data[15:0];
            nwalk_pkg::REG_HEIGHT:         h_reg  = data[12:0];
            nwalk_pkg::REG_WIDTH:          w_reg  = data[12:0];
            nwalk_pkg::REG_BLOCK_CHANNELS: c0_reg = data[5:0];
            nwalk_pkg::REG_ELEM_BYTES:     eb_reg = data[3:0];
            default: return;
        endcase
        rewind();
    endfunction

    function t_elem_addr predict_element(bit restart_bit);
        longint unsigned n, c, h, w, c0, eb, c1, ch, src, dst;
        bit              pad, last;
        t_elem_addr      e;
        n  = clampv(n_reg, 65535);
        c  = clampv(c_reg, 65535);
        h  = clampv(h_reg, 4096);
        w  = clampv(w_reg, 4096);
        c0 = clampv(c0_reg, 32);
        eb = clampv(eb_reg, 8);
        c1 = (c - 1) / c0 + 1;
        if (restart_bit) rewind();
        ch  = blk * c0 + lane;
        pad = (ch >= c);
        if (pad) src = 0;
        else src = ((((bat * c + ch) * h + row) * w + col) * eb) & ADDR_MASK;
        dst  = (lin * eb) & ADDR_MASK;
        last = (lane + 1 >= c0) && (col + 1 >= w) && (row + 1 >= h) &&
               (blk + 1 >= c1) && (bat + 1 >= n);
        e.src  = src[39:0];
        e.dst  = dst[39:0];
        e.pad  = pad;
        e.last = last;
        if (last) begin
            rewind();
        end else begin
            lin = (lin + 1) & ADDR_MASK;
            lane++;
            if (lane >= c0) begin
                lane = 0;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                    if (row >= h) begin
                        row = 0;
                        blk++;
                        if (blk >= c1) begin
                            blk = 0;
                            bat++;
                        end
                    end
                end
            end
        end
        return e;
    endfunction

    function void note_request(logic restart_bit);
        pending_elems.insert(pending_elems.size(), predict_element(restart_bit));
    endfunction

    function void check_element(logic [39:0] src, logic [39:0] dst, logic pad, logic last);
        t_elem_addr want;
        if (pending_elems.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("tb: element with none expected: src %h dst %h pad %b last %b",
                         src, dst, pad, last);
            return;
        end
        want = pending_elems.pop_front();
        if (want.src !== src || want.dst !== dst || want.pad !== pad || want.last !== last)
        begin
            err_count++;
            if (err_count <= 10)
                $display("tb: mismatch: exp src %h dst %h pad %b last %b, ",
                         want.src, want.dst, want.pad, want.last,
                         "got src %h dst %h pad %b last %b", src, dst, pad, last);
        end
    endfunction
endclass

module tb;
    import nwalk_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_restart;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [39:0]               o_src_offset;
    logic [39:0]               o_dst_offset;
    logic                      o_pad;
    logic                      o_last_element;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    walk_scoreboard sb;
    bit             no_idle;
    int             cycle_count = 0;

    nchw_to_nc1hwc0_address_walker_top #(
        .ADDR_BITS(40)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_src_offset   (o_src_offset),
        .o_dst_offset   (o_dst_offset),
        .o_pad          (o_pad),
        .o_last_element (o_last_element),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_restart);
            if (o_out_valid && i_out_ready)
                sb.check_element(o_src_offset, o_dst_offset, o_pad, o_last_element);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: bursts of ready, short stalls, a few long ones, and calm stretches
    initial begin
        int r;
        int len;
        i_out_ready = 1'b1;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                i_out_ready = 1'b1;
                len = $urandom_range(100, 300);
            end else if (r < 60) begin
                i_out_ready = 1'b1;
                len = $urandom_range(1, 8);
            end else begin
                i_out_ready = 1'b0;
                len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
            end
            repeat (len) @(negedge i_clk);
        end
    end

    task automatic send_item(input logic restart_bit);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_restart  = restart_bit;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic run_items(input int count, input int restart_pct);
        for (int k = 0; k < count; k++)
            send_item($urandom_range(0, 99) < restart_pct);
    endtask

    // Hold off until every element has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        sb.apply_write(idx, data);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_geometry(input logic [15:0] bn, input logic [15:0] bc,
                                input logic [15:0] bh, input logic [15:0] bw,
                                input logic [15:0] bc0, input logic [15:0] beb);
        write_reg(REG_BATCH_COUNT, bn);
        write_reg(REG_CHANNEL_COUNT, bc);
        write_reg(REG_HEIGHT, bh);
        write_reg(REG_WIDTH, bw);
        write_reg(REG_BLOCK_CHANNELS, bc0);
        write_reg(REG_ELEM_BYTES, beb);
        end_writes();
    endtask

    function automatic logic [15:0] small_value(input logic [CFG_INDEX_BITS-1:0] idx);
        if ($urandom_range(0, 9) == 0) return 16'd0;
        case (idx)
            REG_BATCH_COUNT:    return 16'($urandom_range(1, 2));
            REG_CHANNEL_COUNT:
                return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(21, 64))
                                                   : 16'($urandom_range(1, 20));
            REG_HEIGHT:         return 16'($urandom_range(1, 3));
            REG_WIDTH:          return 16'($urandom_range(1, 3));
            REG_BLOCK_CHANNELS:
                return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 32))
                                                   : 16'($urandom_range(1, 8));
            default:            return 16'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        logic [CFG_INDEX_BITS-1:0] idx;
        sb          = new();
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_BATCH_COUNT;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry, with a restart partway through
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        // Two batches, three channels in blocks of four: pad lanes, last element, wrap
        set_geometry(16'd2, 16'd3, 16'd1, 16'd1, 16'd4, 16'd2);
        run_items(10, 0);
        drain();
        // Zero registers count as one: every element is the last
        set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_items(3, 0);
        drain();
        // Largest sizes, with H, C0 and element size above their limits
        set_geometry(16'hFFFF, 16'hFFFF, 16'd8191, 16'd4096, 16'd63, 16'd15);
        run_items(4, 0);
        drain();
        // Writes beyond the register list leave the walk where it is
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h5A5A);
        end_writes();
        run_items(3, 0);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            no_idle = (phase % 4 == 2);
            if (phase == 3) begin
                set_geometry(16'($urandom_range(1000, 65535)),
                             16'($urandom_range(1000, 65535)),
                             ($urandom_range(0, 1) != 0) ? 16'd8191
                                                         : 16'($urandom_range(4000, 4096)),
                             16'($urandom_range(4000, 4096)),
                             16'($urandom_range(17, 63)),
                             16'($urandom_range(5, 15)));
                run_items(40, 2);
            end else if (phase == 7) begin
                // Full-width noise on every index, spare ones included
                for (int k = 0; k < 8; k++) begin
                    idx = CFG_INDEX_BITS'(k);
                    write_reg(idx, 16'($urandom_range(0, 65535)));
                end
                end_writes();
                run_items(100, 3);
            end else begin
                for (int k = 0; k < 6; k++) begin
                    idx = CFG_INDEX_BITS'(k);
                    if ($urandom_range(0, 3) != 0) write_reg(idx, small_value(idx));
                end
                end_writes();
                run_items($urandom_range(90, 130), 3);
            end
            drain();
        end
        no_idle = 1'b0;

        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
